/* sv/mlpq_pkg.sv */
// Shared types and constants of the multilevel priority FIFO.
// Holds the transfer payload structs, action and status codes, parameter defaults.
// No dependencies.
package mlpq_pkg;

    localparam int DEF_LEVELS  = 8;
    localparam int DEF_ENTRIES = 64;
    localparam int DEF_ID_BITS = 16;

    localparam int ACTION_W = 2;
    localparam int PRIO_W   = 3;
    localparam int PID_W    = 16;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_EXECUTE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PRIO_W-1:0]   priority_req;
        logic [PID_W-1:0]    proc_id;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    out_id;
        logic [PRIO_W-1:0]   out_level;
    } t_out;

endpackage

/* sv/mlpq_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Used for the node contents and the node link fields. No dependencies.
module mlpq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/multilevel_priority_fifo_core.sv */
// Top level of the multilevel priority FIFO: control sequencer and level list ends.
// Depends on mlpq_pkg and mlpq_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one request per
//   transfer: insert an id at the tail of a level, execute (pop the head of the
//   most urgent non-empty level) or find the most urgent level holding an id.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
//   result per request, in order.
//   Nodes live in a shared pool kept in two single-port-read RAMs (contents and
//   links); list heads and tails sit in registers.
//   Work per request, from transfer in to result valid:
//     insert  scans the pool RAM once from node 0 up to the lowest free node
//     execute one read and one write-back of the head node
//     find    every node is read once from the pool RAM
//     refused insert, empty execute, unused action: straight to the result
//   One request is in work at a time; the next is taken in the cycle after the
//   result is loaded into the output register, even while that result still waits.
//   After reset a clearing pass marks every node free; no request is taken
//   during it. A stalled receiver holds the result register and the sequencer
//   waits before loading the following result.
module multilevel_priority_fifo_core #(
    parameter int LEVELS  = mlpq_pkg::DEF_LEVELS,
    parameter int ENTRIES = mlpq_pkg::DEF_ENTRIES,
    parameter int ID_BITS = mlpq_pkg::DEF_ID_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mlpq_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mlpq_pkg::t_out o_out_data
);

    import mlpq_pkg::*;

    localparam int NW = $clog2(ENTRIES);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int AW = 1 + LW + ID_BITS;

    localparam logic [NW-1:0] LAST_NODE = NW'(ENTRIES - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(ENTRIES);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ISCAN  = 3'd2;
    localparam logic [2:0] S_XREAD  = 3'd3;
    localparam logic [2:0] S_XWRITE = 3'd4;
    localparam logic [2:0] S_FSCAN  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        r_state, n_state;
    t_in               r_req, n_req;
    logic [NW-1:0]     r_addr, n_addr;
    logic [NW-1:0]     r_rd_addr, n_rd_addr;
    logic              r_rd_vld, n_rd_vld;
    logic [LW-1:0]     r_lv, n_lv;
    logic              r_found, n_found;
    logic [LW-1:0]     r_best, n_best;
    t_out              r_res, n_res;
    logic [CW-1:0]     r_count, n_count;
    logic [NW-1:0]     r_head [LEVELS];
    logic [NW-1:0]     n_head [LEVELS];
    logic [NW-1:0]     r_tail [LEVELS];
    logic [NW-1:0]     n_tail [LEVELS];
    logic [LEVELS-1:0] r_nonempty, n_nonempty;
    logic              r_out_valid, n_out_valid;
    t_out              r_out_data, n_out_data;

    logic              a_we, b_we;
    logic [NW-1:0]     a_waddr, b_waddr, a_raddr;
    logic [AW-1:0]     a_wdata, a_rdata;
    logic [NW-1:0]     b_wdata, b_rdata;

    logic              rd_used;
    logic [LW-1:0]     rd_lvl;
    logic [ID_BITS-1:0] rd_id;
    logic [ID_BITS-1:0] req_id;
    logic [LW-1:0]     ins_lv;
    logic [LW-1:0]     low_lv;
    logic              any_ne;
    logic              find_hit;
    logic              f_found;
    logic [LW-1:0]     f_best;
    logic [NW-1:0]     x_head;

    mlpq_ram #(.DEPTH(ENTRIES), .WIDTH(AW)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mlpq_ram #(.DEPTH(ENTRIES), .WIDTH(NW)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (x_head),
        .o_rdata (b_rdata)
    );

    assign rd_used = a_rdata[AW-1];
    assign rd_lvl  = a_rdata[LW+ID_BITS-1:ID_BITS];
    assign rd_id   = a_rdata[ID_BITS-1:0];
    assign req_id  = ID_BITS'(r_req.proc_id);
    assign ins_lv  = (int'(r_req.priority_req) >= LEVELS) ? LW'(LEVELS - 1)
                                                          : LW'(r_req.priority_req);
    assign x_head  = r_head[r_lv];
    assign a_raddr = (r_state == S_XREAD) ? x_head : r_addr;
    assign any_ne  = |r_nonempty;

    always_comb begin
        low_lv = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                low_lv = LW'(i);
            end
        end
    end

    assign find_hit = r_rd_vld && rd_used && (rd_id == req_id)
                      && (!r_found || (rd_lvl < r_best));
    assign f_found  = r_found || find_hit;
    assign f_best   = find_hit ? rd_lvl : r_best;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_addr      = r_addr;
        n_rd_addr   = r_rd_addr;
        n_rd_vld    = 1'b0;
        n_lv        = r_lv;
        n_found     = r_found;
        n_best      = r_best;
        n_res       = r_res;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_nonempty  = r_nonempty;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        a_we        = 1'b0;
        a_waddr     = r_addr;
        a_wdata     = '0;
        b_we        = 1'b0;
        b_waddr     = r_tail[ins_lv];
        b_wdata     = r_rd_addr;

        unique case (r_state)
            S_CLEAR: begin
                a_we = 1'b1;
                if (r_addr == LAST_NODE) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_addr  = '0;
                    n_found = 1'b0;
                    n_best  = '0;
                    n_res   = '{status: ST_OK, out_id: '0, out_level: '0};
                    unique case (i_in_data.action)
                        ACT_INSERT: begin
                            if (r_count == FULL_CNT) begin
                                n_res.status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_ISCAN;
                            end
                        end
                        ACT_EXECUTE: begin
                            if (any_ne) begin
                                n_lv    = low_lv;
                                n_state = S_XREAD;
                            end else begin
                                n_res.status = ST_EMPTY;
                                n_state      = S_DONE;
                            end
                        end
                        ACT_FIND: begin
                            n_state = S_FSCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_ISCAN: begin
                if (r_rd_vld && !rd_used) begin
                    a_we    = 1'b1;
                    a_waddr = r_rd_addr;
                    a_wdata = {1'b1, ins_lv, req_id};
                    if (r_nonempty[ins_lv]) begin
                        b_we = 1'b1;
                    end else begin
                        n_head[ins_lv]     = r_rd_addr;
                        n_nonempty[ins_lv] = 1'b1;
                    end
                    n_tail[ins_lv] = r_rd_addr;
                    n_count        = r_count + 1'b1;
                    n_state        = S_DONE;
                end else begin
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_addr;
                    if (r_addr != LAST_NODE) begin
                        n_addr = r_addr + 1'b1;
                    end
                end
            end
            S_XREAD: begin
                n_state = S_XWRITE;
            end
            S_XWRITE: begin
                a_we    = 1'b1;
                a_waddr = x_head;
                a_wdata = {1'b0, rd_lvl, rd_id};
                if (x_head == r_tail[r_lv]) begin
                    n_nonempty[r_lv] = 1'b0;
                end else begin
                    n_head[r_lv] = b_rdata;
                end
                n_count = r_count - 1'b1;
                n_res   = '{status: ST_OK, out_id: PID_W'(rd_id), out_level: PRIO_W'(r_lv)};
                n_state = S_DONE;
            end
            S_FSCAN: begin
                n_found = f_found;
                n_best  = f_best;
                if (r_rd_vld && (r_rd_addr == LAST_NODE)) begin
                    if (f_found) begin
                        n_res = '{status: ST_OK, out_id: '0, out_level: PRIO_W'(f_best)};
                    end else begin
                        n_res = '{status: ST_EMPTY, out_id: '0, out_level: '0};
                    end
                    n_state = S_DONE;
                end else begin
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_addr;
                    if (r_addr != LAST_NODE) begin
                        n_addr = r_addr + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
            r_nonempty  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_rd_vld    <= n_rd_vld;
            r_count     <= n_count;
            r_nonempty  <= n_nonempty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_rd_addr  <= n_rd_addr;
        r_lv       <= n_lv;
        r_found    <= n_found;
        r_best     <= n_best;
        r_res      <= n_res;
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_out_data <= n_out_data;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("node count above pool size");

    a_empty_lists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_nonempty == '0))
        else $error("level marked non-empty with no nodes in use");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XWRITE) |=> (r_count + 1'b1 == $past(r_count)))
        else $error("execute did not release exactly one node");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the done step");

endmodule
